@@ rtl/gcfsm_pkg.sv @@
// shared types and constants of the glyph cache slot manager
package gcfsm_pkg;

   // opcode values on the request side
   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_INSERT = 1'b1;

   // register index decoded from the csr address
   localparam logic REG_MAX_GLYPH_SIZE = 1'b0;
   localparam logic REG_SLOT_LIMIT     = 1'b1;

   localparam logic [7:0] MAX_GLYPH_SIZE_RST = 8'd32;
   localparam logic [8:0] SLOT_LIMIT_RST     = 9'd256;

   // command queue between front and back
   localparam int Q_DEPTH = 2;
   localparam int QP_W    = $clog2(Q_DEPTH);
   localparam int QC_W    = $clog2(Q_DEPTH + 1);

   localparam int TAG_W  = 24;
   localparam int CODE_MAX_W = 16;

   typedef enum logic [2:0] {
      ST_HIT       = 3'd0,
      ST_MISS      = 3'd1,
      ST_STORED    = 3'd2,
      ST_PRESENT   = 3'd3,
      ST_TOO_LARGE = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CMD_LOOKUP    = 2'd0,
      CMD_INSERT    = 2'd1,
      CMD_TOO_LARGE = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type               kind;
      logic [CODE_MAX_W-1:0]  code;
      logic [TAG_W-1:0]       tag;
   } cmd_type;

endpackage

@@ rtl/gcfsm_ram.sv @@
// generic simple dual-port ram with registered read
module gcfsm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [ADDR_W-1:0]        waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [ADDR_W-1:0]        raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

@@ rtl/gcfsm_front.sv @@
// front end: accepts request beats, reduces the code, classifies and queues commands
module gcfsm_front import gcfsm_pkg::*; #(
   parameter int CODES = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        enable,
   input  logic [7:0]  max_glyph_size,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic [0:0]  req_tuser,
   output logic        cmd_valid,
   output cmd_type     cmd,
   input  logic        cmd_pop
);
   cmd_type             q_ff [Q_DEPTH];
   logic [QP_W-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [QC_W-1:0]     count_ff, count_in;
   logic                push;
   cmd_type             cls;
   logic [23:0]         rem;

   // code modulo CODES, one conditional subtract per quotient bit
   always_comb begin
      rem = {8'b0, req_tdata[15:0]};
      for (int i = 7; i >= 0; i--) begin
         if (rem >= (24'(CODES) << i)) begin
            rem = rem - (24'(CODES) << i);
         end
      end
      cls.code = rem[15:0];
      cls.tag  = {req_tdata[23:16], req_tdata[31:24], req_tdata[39:32]};
      if (req_tuser[0] == OP_LOOKUP) begin
         cls.kind = CMD_LOOKUP;
      end else if (req_tdata[31:24] > max_glyph_size) begin
         cls.kind = CMD_TOO_LARGE;
      end else begin
         cls.kind = CMD_INSERT;
      end
   end

   assign req_tready = enable && (count_ff != QC_W'(Q_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = (count_ff != '0);
   assign cmd        = q_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == QP_W'(Q_DEPTH - 1)) ? '0 : wr_ff + QP_W'(1);
      end
      if (cmd_pop) begin
         rd_in = (rd_ff == QP_W'(Q_DEPTH - 1)) ? '0 : rd_ff + QP_W'(1);
      end
      case ({push, cmd_pop})
         2'b10:   count_in = count_ff + QC_W'(1);
         2'b01:   count_in = count_ff - QC_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= cls;
      end
   end

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> count_ff != '0)
      else $error("command popped from empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QC_W'(Q_DEPTH))
      else $error("command queue overfilled");
endmodule

@@ rtl/gcfsm_back.sv @@
// back end: code map clearing, map and slot table sequencer, result register
module gcfsm_back import gcfsm_pkg::*; #(
   parameter int SLOTS = 256,
   parameter int CODES = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [8:0]  slot_limit,
   input  logic        cmd_valid,
   input  cmd_type     cmd,
   output logic        cmd_pop,
   output logic        clearing,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [2:0]  rsp_tuser,
   output logic [31:0] rsp_tdata
);
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int USED_W = $clog2(SLOTS + 1);
   localparam int CODE_W = $clog2(CODES);
   localparam int LIM_W  = (USED_W > 9) ? USED_W : 9;
   localparam int SE_W   = CODE_W + TAG_W;

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_MAP   = 7'b0000100,
      S_TAG   = 7'b0001000,
      S_EVICT = 7'b0010000,
      S_REMAP = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type           state_ff, state_in;
   cmd_type             cur_ff, cur_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [USED_W-1:0]   used_ff, used_in;
   logic [SLOT_W-1:0]   oldest_ff, oldest_in;
   logic [CODE_W-1:0]   clr_ff, clr_in;
   status_type          res_status_ff, res_status_in;
   logic [7:0]          res_slot_ff, res_slot_in;
   logic                res_ev_ff, res_ev_in;
   logic [15:0]         res_evcode_ff, res_evcode_in;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff;
   logic [31:0]         rsp_data_ff;
   logic                load;

   logic                map_we;
   logic [CODE_W-1:0]   map_waddr, map_raddr;
   logic [SLOT_W:0]     map_wdata, map_rdata;
   logic                se_we;
   logic [SLOT_W-1:0]   se_waddr, se_raddr;
   logic [SE_W-1:0]     se_wdata, se_rdata;

   logic                map_hit;
   logic [SLOT_W-1:0]   map_slot;
   logic [SLOT_W-1:0]   used_slot, victim, next_oldest;
   logic [LIM_W-1:0]    lim_x, eff_lim;
   logic                fresh;
   logic [CODE_W-1:0]   rd_code;
   logic [TAG_W-1:0]    rd_tag;

   gcfsm_ram #(.WIDTH(SLOT_W + 1), .DEPTH(CODES)) u_code_map (
      .clock (clock),
      .we    (map_we),
      .waddr (map_waddr),
      .wdata (map_wdata),
      .raddr (map_raddr),
      .rdata (map_rdata)
   );

   // slot entry: code served in the upper bits, tag in the lower
   gcfsm_ram #(.WIDTH(SE_W), .DEPTH(SLOTS)) u_slot_table (
      .clock (clock),
      .we    (se_we),
      .waddr (se_waddr),
      .wdata (se_wdata),
      .raddr (se_raddr),
      .rdata (se_rdata)
   );

   assign map_hit   = map_rdata[SLOT_W];
   assign map_slot  = map_rdata[SLOT_W-1:0];
   assign used_slot = used_ff[SLOT_W-1:0];
   assign rd_code   = se_rdata[SE_W-1:TAG_W];
   assign rd_tag    = se_rdata[TAG_W-1:0];

   // effective limit: zero acts as one, clipped to the slot count
   always_comb begin
      lim_x = LIM_W'(slot_limit);
      if (lim_x == '0) begin
         eff_lim = LIM_W'(1);
      end else if (lim_x > LIM_W'(SLOTS)) begin
         eff_lim = LIM_W'(SLOTS);
      end else begin
         eff_lim = lim_x;
      end
      fresh = LIM_W'(used_ff) < eff_lim;
   end

   // round-robin victim over slots in use
   always_comb begin
      victim = (USED_W'(oldest_ff) >= used_ff) ? '0 : oldest_ff;
      next_oldest = ((USED_W'(victim) + USED_W'(1)) >= used_ff) ? '0 : victim + SLOT_W'(1);
   end

   assign map_raddr = cmd.code[CODE_W-1:0];
   assign se_raddr  = (cur_ff.kind == CMD_LOOKUP) ? map_slot : victim;

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      slot_in       = slot_ff;
      used_in       = used_ff;
      oldest_in     = oldest_ff;
      clr_in        = clr_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_ev_in     = res_ev_ff;
      res_evcode_in = res_evcode_ff;
      map_we        = 1'b0;
      map_waddr     = cur_ff.code[CODE_W-1:0];
      map_wdata     = '0;
      se_we         = 1'b0;
      se_waddr      = slot_ff;
      se_wdata      = {cur_ff.code[CODE_W-1:0], cur_ff.tag};
      cmd_pop       = 1'b0;
      load          = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            map_we    = 1'b1;
            map_waddr = clr_ff;
            clr_in    = clr_ff + CODE_W'(1);
            if (clr_ff == CODE_W'(CODES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               cur_in  = cmd;
               if (cmd.kind == CMD_TOO_LARGE) begin
                  res_status_in = ST_TOO_LARGE;
                  res_slot_in   = '0;
                  res_ev_in     = 1'b0;
                  res_evcode_in = '0;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_MAP;
               end
            end
         end
         S_MAP: begin
            res_slot_in   = '0;
            res_ev_in     = 1'b0;
            res_evcode_in = '0;
            if (cur_ff.kind == CMD_LOOKUP) begin
               if (map_hit) begin
                  slot_in  = map_slot;
                  state_in = S_TAG;
               end else begin
                  res_status_in = ST_MISS;
                  state_in      = S_DONE;
               end
            end else if (map_hit) begin
               res_status_in = ST_PRESENT;
               state_in      = S_DONE;
            end else if (fresh) begin
               se_we         = 1'b1;
               se_waddr      = used_slot;
               map_we        = 1'b1;
               map_wdata     = {1'b1, used_slot};
               used_in       = used_ff + USED_W'(1);
               res_status_in = ST_STORED;
               res_slot_in   = 8'(used_slot);
               state_in      = S_DONE;
            end else begin
               slot_in   = victim;
               oldest_in = next_oldest;
               state_in  = S_EVICT;
            end
         end
         S_TAG: begin
            if (rd_tag == cur_ff.tag) begin
               res_status_in = ST_HIT;
               res_slot_in   = 8'(slot_ff);
            end else begin
               res_status_in = ST_MISS;
               res_slot_in   = '0;
            end
            state_in = S_DONE;
         end
         S_EVICT: begin
            map_we        = 1'b1;
            map_waddr     = rd_code;
            map_wdata     = '0;
            se_we         = 1'b1;
            res_status_in = ST_STORED;
            res_slot_in   = 8'(slot_ff);
            res_ev_in     = 1'b1;
            res_evcode_in = 16'(rd_code);
            state_in      = S_REMAP;
         end
         S_REMAP: begin
            map_we    = 1'b1;
            map_wdata = {1'b1, slot_ff};
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         used_ff      <= '0;
         oldest_ff    <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         oldest_ff    <= oldest_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      slot_ff       <= slot_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_ev_ff     <= res_ev_in;
      res_evcode_ff <= res_evcode_in;
      if (load) begin
         rsp_status_ff <= res_status_ff;
         rsp_data_ff   <= {7'b0, res_evcode_ff, res_ev_ff, res_slot_ff};
      end
   end

   assign clearing   = (state_ff == S_CLEAR);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= USED_W'(SLOTS))
      else $error("more slots in use than exist");

   a_oldest_bound: assert property (@(posedge clock) disable iff (reset)
      (oldest_ff == '0) || (USED_W'(oldest_ff) < used_ff))
      else $error("replacement pointer beyond slots in use");

   a_no_pop_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !cmd_pop)
      else $error("command taken during code map clearing");
endmodule

@@ rtl/glyph_cache_fifo_slot_manager_top.sv @@
// top level of the glyph cache slot manager: csr block, front end and back end
//
// glyph cache slot manager. each request beat is a lookup or an insert keyed by
// a character code; the code map (one entry per code) points to a slot whose
// tag (font, size, style) must match for a lookup to hit. inserts above
// max_glyph_size are rejected, inserts of a mapped code report already present,
// other inserts take a fresh slot until slot_limit slots are in use and then
// replace the oldest slot round robin, unmapping its code. one response beat
// per request beat, in order. after reset the code map is cleared one entry a
// cycle over all CODES entries, req_tready low and csr writes taken meanwhile.
// in the back end sequencer a rejected insert passes idle and done; a miss, an
// already present insert or a fresh store idle, map and done; a lookup that
// reaches the tag compare idle, map, tag and done; a store that replaces a slot
// idle, map, evict, remap, done, the code map's single write port serializing
// the unmap and the remap. the front end accepts and queues up to two requests
// while the back end works and while a response waits in the output register.
module glyph_cache_fifo_slot_manager_top import gcfsm_pkg::*; #(
   parameter int SLOTS = 256,
   parameter int CODES = 65536
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // char_code, font_id, glyph_size, glyph_style
   input  logic [0:0]  req_tuser,   // opcode
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [2:0]  rsp_tuser,   // status
   output logic [31:0] rsp_tdata,   // slot, evicted_valid, evicted_code, zero pad
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   logic [7:0] max_size_ff, max_size_in;
   logic [8:0] limit_ff, limit_in;
   logic       csr_write;
   logic       cmd_valid;
   cmd_type    cmd;
   logic       cmd_pop;
   logic       clearing;

   // register file: max_glyph_size at 0x0, slot_limit at 0x4
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      max_size_in = max_size_ff;
      limit_in    = limit_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            REG_MAX_GLYPH_SIZE: max_size_in = csr_pwdata[7:0];
            REG_SLOT_LIMIT:     limit_in    = csr_pwdata[8:0];
            default:            max_size_in = max_size_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_MAX_GLYPH_SIZE: csr_prdata = {24'b0, max_size_ff};
         REG_SLOT_LIMIT:     csr_prdata = {23'b0, limit_ff};
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_size_ff <= MAX_GLYPH_SIZE_RST;
         limit_ff    <= SLOT_LIMIT_RST;
      end else begin
         max_size_ff <= max_size_in;
         limit_ff    <= limit_in;
      end
   end

   // front end: code reduction, size check, command queue
   gcfsm_front #(.CODES(CODES)) u_front (
      .clock          (clock),
      .reset          (reset),
      .enable         (!clearing),
      .max_glyph_size (max_size_ff),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_pop        (cmd_pop)
   );

   // back end: code map and slot table sequencer, response register
   gcfsm_back #(.SLOTS(SLOTS), .CODES(CODES)) u_back (
      .clock      (clock),
      .reset      (reset),
      .slot_limit (limit_ff),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .clearing   (clearing),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );
endmodule

@@ tb/sv/glyph_cache_checker.sv @@
// checker for the glyph cache slot manager: predicts every response beat and compares it
module glyph_cache_checker import gcfsm_pkg::*; #(
   parameter int SLOTS = 256,
   parameter int CODES = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,   // char_code, font_id, glyph_size, glyph_style
   input  logic [0:0]  req_tuser,   // opcode
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [2:0]  rsp_tuser,   // status
   input  logic [31:0] rsp_tdata,   // slot, evicted_valid, evicted_code, zero pad
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      status_type  status;
      logic [7:0]  slot;
      logic        ev;
      logic [15:0] ev_code;
   } glyph_rsp_type;

   glyph_rsp_type  glyph_rsp_q[$];

   // shadow of the registers and of the cache state
   logic [7:0]  cfg_max_size;
   logic [8:0]  cfg_slot_limit;
   bit          map_valid [CODES];
   logic [7:0]  map_slot [CODES];
   logic [15:0] slot_code [SLOTS];
   logic [23:0] slot_tag [SLOTS];
   int          slots_used;
   int          oldest_slot;
   int          rsp_count;

   function automatic glyph_rsp_type predict_glyph_rsp(logic op, logic [15:0] code,
                                                       logic [23:0] tag, logic [7:0] size);
      glyph_rsp_type r;
      int lim;
      int s;
      logic [15:0] old;
      r.status  = ST_MISS;
      r.slot    = 8'd0;
      r.ev      = 1'b0;
      r.ev_code = 16'd0;
      lim = (cfg_slot_limit == 0) ? 1 : ((cfg_slot_limit > SLOTS) ? SLOTS : cfg_slot_limit);
      if (op == OP_LOOKUP) begin
         if (map_valid[code] && slot_tag[map_slot[code]] == tag) begin
            r.status = ST_HIT;
            r.slot   = map_slot[code];
         end
      end else if (size > cfg_max_size) begin
         r.status = ST_TOO_LARGE;
      end else if (map_valid[code]) begin
         r.status = ST_PRESENT;
      end else begin
         if (slots_used < lim) begin
            s = slots_used;
            slots_used++;
         end else begin
            // round robin over the slots in use, unmapping the old code
            s = (oldest_slot >= slots_used) ? 0 : oldest_slot;
            oldest_slot = (s + 1 >= slots_used) ? 0 : s + 1;
            old = slot_code[s];
            map_valid[old] = 1'b0;
            r.ev      = 1'b1;
            r.ev_code = old;
         end
         slot_code[s]   = code;
         slot_tag[s]    = tag;
         map_valid[code] = 1'b1;
         map_slot[code]  = s[7:0];
         r.status = ST_STORED;
         r.slot   = s[7:0];
      end
      return r;
   endfunction

   always @(posedge clock) begin
      glyph_rsp_type exp_rsp;
      if (reset) begin
         cfg_max_size   = MAX_GLYPH_SIZE_RST;
         cfg_slot_limit = SLOT_LIMIT_RST;
         for (int i = 0; i < CODES; i++) map_valid[i] = 1'b0;
         slots_used  = 0;
         oldest_slot = 0;
         rsp_count   = 0;
         glyph_rsp_q.delete();
         fail_count  <= 0;
         outstanding <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == REG_MAX_GLYPH_SIZE) cfg_max_size = csr_pwdata[7:0];
            else cfg_slot_limit = csr_pwdata[8:0];
         end
         // compare before predicting so a beat never matches an expectation of the same edge
         if (rsp_tvalid && rsp_tready) begin
            rsp_count++;
            if (glyph_rsp_q.size() == 0) begin
               if (fail_count < 10)
                  $display("rsp beat %0d unexpected: got user %h data %h",
                           rsp_count, rsp_tuser, rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               exp_rsp = glyph_rsp_q.pop_front();
               if (rsp_tuser !== exp_rsp.status || rsp_tdata[7:0] !== exp_rsp.slot ||
                   rsp_tdata[8] !== exp_rsp.ev || rsp_tdata[24:9] !== exp_rsp.ev_code) begin
                  if (fail_count < 10)
                     $display({"rsp beat %0d mismatch: exp status %0d slot %0d ev %0b ",
                               "code %h, got status %0d slot %0d ev %0b code %h"},
                              rsp_count, exp_rsp.status, exp_rsp.slot, exp_rsp.ev,
                              exp_rsp.ev_code, rsp_tuser, rsp_tdata[7:0],
                              rsp_tdata[8], rsp_tdata[24:9]);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready)
            glyph_rsp_q.push_back(predict_glyph_rsp(req_tuser[0], req_tdata[15:0],
                                                    {req_tdata[23:16], req_tdata[31:24],
                                                     req_tdata[39:32]},
                                                    req_tdata[31:24]));
         outstanding <= glyph_rsp_q.size();
      end
   end

endmodule

@@ tb/sv/tb_top.sv @@
// testbench top of the glyph cache slot manager: clock, reset, stimulus and verdict
module tb_top;
   import gcfsm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;   // char_code, font_id, glyph_size, glyph_style
   logic [0:0]  req_tuser;   // opcode
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [2:0]  rsp_tuser;   // status
   logic [31:0] rsp_tdata;   // slot, evicted_valid, evicted_code, zero pad
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int          fail_count;
   int          outstanding;

   // idle rates in percent per cycle, changed per phase
   int          snd_idle_pct;
   int          rcv_idle_pct;
   // long receiver hold-off, run by its own process
   bit          pressure_go;
   logic        hold_rsp;

   // current max_glyph_size, so that most random inserts fit
   logic [7:0]  cur_max;
   // recently inserted codes and tags, reused for hits and already present inserts
   logic [15:0] recent_code[$];
   logic [23:0] recent_tag[$];

   glyph_cache_fifo_slot_manager_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tuser   (rsp_tuser),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   glyph_cache_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tuser   (rsp_tuser),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver: random stalls, or a solid hold-off while the pressure window is open
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_tready <= !hold_rsp && ($urandom_range(0, 99) >= rcv_idle_pct);
      end
   end

   // pressure window: the receiver holds off so the queue fills and req_tready
   // drops while the sender keeps offering beats
   initial begin
      hold_rsp <= 1'b0;
      wait (pressure_go);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (400) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // the clearing pass after reset covers 65536 code map entries; the rest of the run is far shorter
   initial begin
      #5_000_000;
      $display("glyph_cache_fifo_slot_manager_top verification failed");
      $finish;
   end

   // one request beat; a random gap first, then hold until accepted
   task automatic send_glyph_beat(input logic op, input logic [15:0] code,
                                  input logic [7:0] font, input logic [7:0] size,
                                  input logic [7:0] style);
      while ($urandom_range(0, 99) < snd_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {style, size, font, code};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // lower the request valid and wait until every predicted response has come back
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // setup phase, access phase, then an idle phase with psel low so writes never touch back to back
   task automatic csr_write(input logic idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      if (idx == REG_MAX_GLYPH_SIZE) cur_max = value[7:0];
   endtask

   // registers only change with the block idle
   task automatic set_config(input logic [31:0] max_size, input logic [31:0] limit);
      wait_drain();
      csr_write(REG_MAX_GLYPH_SIZE, max_size);
      csr_write(REG_SLOT_LIMIT, limit);
   endtask

   // random beat: mostly sensible inserts and lookups of recent glyphs, some near misses
   // (one style bit flipped) and oversize glyphs
   task automatic send_random_glyph(input int ins_pct, input int fresh_pct);
      logic        op;
      logic [15:0] code;
      logic [7:0]  font;
      logic [7:0]  size;
      logic [7:0]  style;
      int          k;
      op = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_LOOKUP;
      if (recent_code.size() != 0 && $urandom_range(0, 99) >= fresh_pct) begin
         k = $urandom_range(0, recent_code.size() - 1);
         code = recent_code[k];
         {font, size, style} = recent_tag[k];
         if ($urandom_range(0, 3) == 0) style = style ^ (8'd1 << $urandom_range(0, 7));
      end else begin
         code  = 16'($urandom_range(0, 65535));
         font  = 8'($urandom_range(0, 255));
         style = 8'($urandom_range(0, 255));
         size  = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, cur_max))
                                              : 8'($urandom_range(0, 255));
      end
      if (op == OP_INSERT) begin
         recent_code.push_back(code);
         recent_tag.push_back({font, size, style});
         if (recent_code.size() > 32) begin
            recent_code.pop_front();
            recent_tag.pop_front();
         end
      end
      send_glyph_beat(op, code, font, size, style);
   endtask

   task automatic run_phase(input int snd, input int rcv, input logic [31:0] max_size,
                            input logic [31:0] limit, input int count, input int ins_pct,
                            input int fresh_pct, input bit with_pressure);
      set_config(max_size, limit);
      snd_idle_pct = snd;
      rcv_idle_pct = rcv;
      if (with_pressure) pressure_go = 1'b1;
      repeat (count) send_random_glyph(ins_pct, fresh_pct);
   endtask

   initial begin
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      pressure_go  = 1'b0;
      cur_max      = MAX_GLYPH_SIZE_RST;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part; a limit of 0 acts as a single slot
      // these writes land during the code map clearing pass
      snd_idle_pct = 12;
      rcv_idle_pct = 63;
      csr_write(REG_MAX_GLYPH_SIZE, 32'd32);
      csr_write(REG_SLOT_LIMIT, 32'd0);
      send_glyph_beat(OP_INSERT, 16'h0000, 8'h00, 8'h00, 8'h00);   // fresh store, slot 0
      send_glyph_beat(OP_LOOKUP, 16'h0000, 8'h00, 8'h00, 8'h00);   // hit
      send_glyph_beat(OP_LOOKUP, 16'h0000, 8'h01, 8'h00, 8'h00);   // mapped, tag differs
      send_glyph_beat(OP_LOOKUP, 16'h1234, 8'h00, 8'h00, 8'h00);   // unmapped code
      send_glyph_beat(OP_INSERT, 16'h0000, 8'h7f, 8'h10, 8'h3c);   // already present, no tag check
      send_glyph_beat(OP_INSERT, 16'hffff, 8'hff, 8'd32, 8'hff);   // size at limit, evicts code 0
      send_glyph_beat(OP_LOOKUP, 16'h0000, 8'h00, 8'h00, 8'h00);   // evicted code misses
      send_glyph_beat(OP_LOOKUP, 16'hffff, 8'hff, 8'd32, 8'hff);   // hit
      send_glyph_beat(OP_INSERT, 16'h5555, 8'h01, 8'd33, 8'h02);   // one above the limit
      send_glyph_beat(OP_LOOKUP, 16'hffff, 8'hff, 8'hff, 8'hff);   // lookup size is not checked
      // raise the limit in the middle of replacement: new slots join the walk
      set_config(32'd32, 32'd3);
      send_glyph_beat(OP_INSERT, 16'h0100, 8'h11, 8'h01, 8'h21);
      send_glyph_beat(OP_INSERT, 16'h0200, 8'h12, 8'h02, 8'h22);
      send_glyph_beat(OP_INSERT, 16'h0300, 8'h13, 8'h03, 8'h23);
      // limit below the slots in use: every insert replaces, cycling over all three
      set_config(32'd255, 32'd2);
      send_glyph_beat(OP_INSERT, 16'h0400, 8'h21, 8'hff, 8'h31);
      send_glyph_beat(OP_INSERT, 16'h0500, 8'h22, 8'hfe, 8'h32);
      send_glyph_beat(OP_INSERT, 16'h0600, 8'h23, 8'hfd, 8'h33);
      send_glyph_beat(OP_INSERT, 16'h0700, 8'h24, 8'hfc, 8'h34);
      send_glyph_beat(OP_LOOKUP, 16'h0400, 8'h21, 8'hff, 8'h31);   // replaced again, misses
      send_glyph_beat(OP_LOOKUP, 16'h0700, 8'h24, 8'hfc, 8'h34);   // hit
      // limit above the slot count acts as the slot count; max size of 0
      set_config(32'd0, 32'd300);
      send_glyph_beat(OP_INSERT, 16'h8000, 8'h80, 8'h01, 8'h80);   // too large
      send_glyph_beat(OP_INSERT, 16'h8000, 8'h80, 8'h00, 8'h80);   // fresh slot 3
      send_glyph_beat(OP_LOOKUP, 16'h8000, 8'h80, 8'h00, 8'h80);   // hit

      // random part: sender 12 / receiver 63, then the reverse, then no idling
      run_phase(12, 63, 32'd255, 32'd16,  100, 55, 50, 1'b0);
      run_phase(12, 63, 32'd0,   32'd1,   60,  55, 50, 1'b0);
      run_phase(63, 12, 32'd128, 32'd64,  100, 55, 50, 1'b0);
      run_phase(63, 12, 32'd32,  32'd511, 120, 60, 70, 1'b0);
      // mostly fresh inserts so all 256 slots fill and replacement starts at full size
      run_phase(0,  0,  32'd255, 32'd256, 260, 90, 90, 1'b1);

      wait_drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("glyph_cache_fifo_slot_manager_top verification clean");
      end else begin
         $display("glyph_cache_fifo_slot_manager_top verification failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/gcfsm_pkg.sv
rtl/gcfsm_ram.sv
rtl/gcfsm_front.sv
rtl/gcfsm_back.sv
rtl/glyph_cache_fifo_slot_manager_top.sv
tb/sv/glyph_cache_checker.sv
tb/sv/tb_top.sv
